// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for clocked implication checks on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hgc_pkg.sv
// ----------------------------------------------------------------------------
// Hashed glyph cache package
// Field widths, stream packing, hash constants, status codes and state types.
// ----------------------------------------------------------------------------
package hgc_pkg;

    localparam int DEF_TABLE_SIZE  = 4096;
    localparam int DEF_HANDLE_BITS = 16;

    localparam int KEY_W       = 21;
    localparam int IN_HANDLE_W = 16;
    localparam int DIM_W       = 12;
    localparam int STATUS_W    = 3;

    localparam int DEF_ENTRY_W = 1 + KEY_W + DEF_HANDLE_BITS + 2 * DIM_W;

    // slave tdata: code_point, new_handle, new_width, new_height, zero pad
    localparam int S_KEY_LSB    = 0;
    localparam int S_HANDLE_LSB = S_KEY_LSB + KEY_W;
    localparam int S_WIDTH_LSB  = S_HANDLE_LSB + IN_HANDLE_W;
    localparam int S_HEIGHT_LSB = S_WIDTH_LSB + DIM_W;
    localparam int S_TDATA_W    = 64;
    localparam int S_TUSER_W    = 2;
    localparam int S_ACTION_BIT = 0;
    localparam int S_RENDER_BIT = 1;

    // master tdata: glyph_handle, glyph_width, glyph_height
    localparam int M_TDATA_W = IN_HANDLE_W + 2 * DIM_W;

    localparam logic [KEY_W-1:0] KEY_SPACE = 21'h20;
    localparam logic [KEY_W-1:0] KEY_DEL   = 21'h7F;

    localparam logic [31:0] HASH_MUL1 = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL2 = 32'h846ca68b;
    localparam int          HASH_SH1  = 16;
    localparam int          HASH_SH2  = 15;
    localparam int          HASH_SH3  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_RENDER_FAIL = 3'd2,
        ST_FULL        = 3'd3,
        ST_CLEARED     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_RD,
        S_CMP
    } fsm_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MUL1,
        HS_MUL2
    } hash_step_t;

endpackage

// File: rtl/core/hgc_hash.sv
// ----------------------------------------------------------------------------
// Hash unit
// Iterative lowbias32 mixer built around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module hgc_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hgc_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [31:0]               hash_value
);
    import hgc_pkg::*;

    hash_step_t  step_reg, step_next;
    logic        done_reg, done_next;
    logic [31:0] v_reg, v_next;
    logic [31:0] key_ext;
    logic [31:0] mul_op;
    logic [31:0] prod;

    assign key_ext = {{(32 - KEY_W){1'b0}}, key};
    assign mul_op  = (step_reg == HS_MUL1) ? HASH_MUL1 : HASH_MUL2;
    assign prod    = v_reg * mul_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= HS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        unique case (step_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    v_next    = key_ext ^ (key_ext >> HASH_SH1);
                    step_next = HS_MUL1;
                end
            end
            HS_MUL1:
            begin
                v_next    = prod ^ (prod >> HASH_SH2);
                step_next = HS_MUL2;
            end
            HS_MUL2:
            begin
                v_next    = prod ^ (prod >> HASH_SH3);
                step_next = HS_IDLE;
                done_next = 1'b1;
            end
            default:
            begin
                step_next = HS_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign hash_value = v_reg;

endmodule

// File: rtl/core/hgc_table.sv
// ----------------------------------------------------------------------------
// Slot table
// Single-write, single-read slot memory with registered read data.
// ----------------------------------------------------------------------------
module hgc_table #(
    parameter int TABLE_SIZE = hgc_pkg::DEF_TABLE_SIZE,
    parameter int ENTRY_W    = hgc_pkg::DEF_ENTRY_W
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]            wr_data,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]            rd_data
);
    import hgc_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/hashed_glyph_cache_unit.sv
// ----------------------------------------------------------------------------
// Hashed glyph cache unit
// Open-addressing glyph cache keyed by code point, linear probing with wrap.
// ----------------------------------------------------------------------------
// One request at a time. A lookup or insert first runs the lowbias32 hash on
// the shared multiplier, then probes slots one after another, each probe being
// a read and a compare on the table's read port. It probes a single slot on a
// first-probe hit or insert, and at most TABLE_SIZE slots. A clear sweeps
// every slot through the write port. After reset the same sweep runs with
// s_tready low. A finished result sits in the output register, and the next
// request is taken while it waits.
module hashed_glyph_cache_unit #(
    parameter int TABLE_SIZE  = hgc_pkg::DEF_TABLE_SIZE,
    parameter int HANDLE_BITS = hgc_pkg::DEF_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // code_point[20:0], new_handle[36:21], new_width[48:37], new_height[60:49]
    input  logic [hgc_pkg::S_TDATA_W-1:0] s_tdata,
    // action[0], render_ok[1]
    input  logic [hgc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // glyph_handle[15:0], glyph_width[27:16], glyph_height[39:28]
    output logic [hgc_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [hgc_pkg::STATUS_W-1:0]  m_tuser
);
    import hgc_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_SIZE);
    localparam int E_VALID   = 0;
    localparam int E_KEY     = E_VALID + 1;
    localparam int E_HANDLE  = E_KEY + KEY_W;
    localparam int E_WIDTH   = E_HANDLE + HANDLE_BITS;
    localparam int E_HEIGHT  = E_WIDTH + DIM_W;
    localparam int ENTRY_W   = E_HEIGHT + DIM_W;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = {SLOT_BITS{1'b1}};
    localparam logic [SLOT_BITS-1:0] SLOT_ONE  = SLOT_BITS'(1);

    fsm_t                   state_reg, state_next;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [SLOT_BITS-1:0]   cnt_reg, cnt_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   render_ok_reg, render_ok_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [DIM_W-1:0]       width_reg, width_next;
    logic [DIM_W-1:0]       height_reg, height_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                m_tuser_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   out_free;
    logic                   out_load;
    status_t                out_status;
    logic [M_TDATA_W-1:0]   out_data;

    logic [KEY_W-1:0]       code_in;
    logic [KEY_W-1:0]       key_mapped;
    logic [HANDLE_BITS+IN_HANDLE_W-1:0] in_handle_ext;

    logic                   hash_start;
    logic                   hash_done;
    logic [31:0]            hash_value;

    logic                   wr_en;
    logic [SLOT_BITS-1:0]   wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;

    logic                   rd_valid;
    logic                   rd_match;
    logic [HANDLE_BITS+IN_HANDLE_W-1:0] hit_handle_ext;
    logic [HANDLE_BITS+IN_HANDLE_W-1:0] ins_handle_ext;
    logic [M_TDATA_W-1:0]   hit_data;
    logic [M_TDATA_W-1:0]   ins_data;
    logic [ENTRY_W-1:0]     ins_entry;

    hgc_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .key        (key_mapped),
        .done       (hash_done),
        .hash_value (hash_value)
    );

    hgc_table #(
        .TABLE_SIZE (TABLE_SIZE),
        .ENTRY_W    (ENTRY_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign code_in    = s_tdata[S_KEY_LSB +: KEY_W];
    assign key_mapped = ((code_in < KEY_SPACE) || (code_in == KEY_DEL)) ? KEY_SPACE
                                                                         : code_in;
    assign in_handle_ext = {{HANDLE_BITS{1'b0}}, s_tdata[S_HANDLE_LSB +: IN_HANDLE_W]};

    assign rd_valid = rd_data[E_VALID];
    assign rd_match = (rd_data[E_KEY +: KEY_W] == key_reg);

    assign hit_handle_ext = {{IN_HANDLE_W{1'b0}}, rd_data[E_HANDLE +: HANDLE_BITS]};
    assign ins_handle_ext = {{IN_HANDLE_W{1'b0}}, handle_reg};
    assign hit_data = {rd_data[E_HEIGHT +: DIM_W], rd_data[E_WIDTH +: DIM_W],
                       hit_handle_ext[IN_HANDLE_W-1:0]};
    assign ins_data = {height_reg, width_reg, ins_handle_ext[IN_HANDLE_W-1:0]};
    assign ins_entry = {height_reg, width_reg, handle_reg, key_reg, 1'b1};

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        render_ok_reg <= render_ok_next;
        handle_reg    <= handle_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        if (out_load)
        begin
            m_tuser_reg <= out_status;
            m_tdata_reg <= out_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        render_ok_next = render_ok_reg;
        handle_next    = handle_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        hash_start     = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '0;
        out_load       = 1'b0;
        out_status     = ST_HIT;
        out_data       = '0;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                cnt_next = cnt_reg + SLOT_ONE;
                if (cnt_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cnt_next = '0;
                    if (s_tuser[S_ACTION_BIT])
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        key_next       = key_mapped;
                        render_ok_next = s_tuser[S_RENDER_BIT];
                        handle_next    = in_handle_ext[HANDLE_BITS-1:0];
                        width_next     = s_tdata[S_WIDTH_LSB +: DIM_W];
                        height_next    = s_tdata[S_HEIGHT_LSB +: DIM_W];
                        hash_start     = 1'b1;
                        state_next     = S_HASH;
                    end
                end
            end
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                if (cnt_reg != SLOT_LAST)
                begin
                    cnt_next = cnt_reg + SLOT_ONE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = ST_CLEARED;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_value[SLOT_BITS-1:0];
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (rd_valid && rd_match)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_status = ST_HIT;
                        out_data   = hit_data;
                        state_next = S_IDLE;
                    end
                end
                else if (!rd_valid)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                        if (render_ok_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = ins_entry;
                            out_status = ST_INSERTED;
                            out_data   = ins_data;
                        end
                        else
                        begin
                            out_status = ST_RENDER_FAIL;
                        end
                    end
                end
                else if (cnt_reg == SLOT_LAST)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_status = ST_FULL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_ONE;
                    cnt_next   = cnt_reg + SLOT_ONE;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/core/hgc_checker.sv
// ----------------------------------------------------------------------------
// Glyph cache port checker
// Port-level checks on results and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hgc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hgc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [hgc_pkg::STATUS_W-1:0]  m_tuser
);
    import hgc_pkg::*;

    `ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `ASSERT_IMPLIES(a_empty_payload, m_tvalid && (m_tuser == ST_RENDER_FAIL || m_tuser == ST_FULL || m_tuser == ST_CLEARED), m_tdata == '0, "non-glyph result carries payload")

    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held after accepted request")

    `ASSERT_IMPLIES(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result raised while idle")

endmodule

bind hashed_glyph_cache_unit hgc_checker u_hgc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/hashed_glyph_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// Hashed glyph cache unit testbench
// Drives lookup, insert and clear requests through the request stream and
// scores every response against an in-bench model of the probing cache.
// Directed checks cover field extremes, control code folding, render
// failure, clear and a completely full table. Random traffic follows, with
// bursts of idle cycles on both streams.
// ----------------------------------------------------------------------------
module hashed_glyph_cache_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hgc_pkg::*;

    localparam int TBL          = DEF_TABLE_SIZE;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int SETTLE       = 64;

    typedef struct packed {
        logic                   action;
        logic [KEY_W-1:0]       code_point;
        logic                   render_ok;
        logic [IN_HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
    } request_t;

    typedef struct packed {
        status_t                status;
        logic [IN_HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
    } glyph_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    bit                     slot_used   [TBL];
    logic [KEY_W-1:0]       slot_code   [TBL];
    logic [IN_HANDLE_W-1:0] slot_handle [TBL];
    logic [DIM_W-1:0]       slot_width  [TBL];
    logic [DIM_W-1:0]       slot_height [TBL];

    glyph_t           pending_glyphs[$];
    logic [KEY_W-1:0] recent_keys[$];
    glyph_t           want;
    int               error_count = 0;
    int unsigned      cycle_count = 0;
    bit               idle_on = 1'b1;

    always #10 clk = ~clk;

    hashed_glyph_cache_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic logic [31:0] lowbias32(logic [31:0] v);
        v = v ^ (v >> HASH_SH1);
        v = v * HASH_MUL1;
        v = v ^ (v >> HASH_SH2);
        v = v * HASH_MUL2;
        v = v ^ (v >> HASH_SH3);
        return v;
    endfunction

    function automatic glyph_t cache_lookup(request_t r);
        glyph_t           g;
        logic [KEY_W-1:0] key;
        int unsigned      slot;
        g.status = ST_FULL;
        g.handle = '0;
        g.width  = '0;
        g.height = '0;
        if (r.action)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            g.status = ST_CLEARED;
            return g;
        end
        key = r.code_point;
        if (key < KEY_SPACE || key == KEY_DEL)
            key = KEY_SPACE;
        slot = lowbias32({{(32-KEY_W){1'b0}}, key}) & (TBL - 1);
        for (int p = 0; p < TBL; p++)
        begin
            if (slot_used[slot])
            begin
                if (slot_code[slot] == key)
                begin
                    g.status = ST_HIT;
                    g.handle = slot_handle[slot];
                    g.width  = slot_width[slot];
                    g.height = slot_height[slot];
                    return g;
                end
            end
            else if (!r.render_ok)
            begin
                g.status = ST_RENDER_FAIL;
                return g;
            end
            else
            begin
                slot_used[slot]   = 1'b1;
                slot_code[slot]   = key;
                slot_handle[slot] = r.handle;
                slot_width[slot]  = r.width;
                slot_height[slot] = r.height;
                g.status = ST_INSERTED;
                g.handle = r.handle;
                g.width  = r.width;
                g.height = r.height;
                return g;
            end
            slot = (slot + 1) & (TBL - 1);
        end
        return g;
    endfunction

    function automatic request_t make_request(logic act, logic [KEY_W-1:0] code, logic ok,
                                              logic [IN_HANDLE_W-1:0] h,
                                              logic [DIM_W-1:0] w, logic [DIM_W-1:0] ht);
        request_t r;
        r.action     = act;
        r.code_point = code;
        r.render_ok  = ok;
        r.handle     = h;
        r.width      = w;
        r.height     = ht;
        return r;
    endfunction

    function automatic request_t random_payload(logic act, logic [KEY_W-1:0] code, logic ok);
        return make_request(act, code, ok, IN_HANDLE_W'($urandom_range(0, 16'hFFFF)),
                            DIM_W'($urandom_range(0, 12'hFFF)),
                            DIM_W'($urandom_range(0, 12'hFFF)));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        $display("mismatch on %s at cycle %0d: got %0h expected %0h",
                 what, cycle_count, got, exp_val);
        error_count++;
    endtask

    task automatic push_request(request_t r);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.height, r.width, r.handle, r.code_point};
        s_tuser  <= {r.render_ok, r.action};
        do @(posedge clk); while (!s_tready);
        pending_glyphs.push_back(cache_lookup(r));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_glyphs.size() != 0);
    endtask

    task automatic test_field_extremes();
        push_request(make_request(1'b0, 21'h1FFFFF, 1'b1, 16'hFFFF, 12'hFFF, 12'hFFF));
        push_request(make_request(1'b0, 21'h1FFFFF, 1'b0, 16'h0000, 12'h000, 12'h000));
        push_request(make_request(1'b0, 21'h000080, 1'b1, 16'h0000, 12'h000, 12'h000));
        push_request(make_request(1'b0, 21'h000080, 1'b1, 16'hFFFF, 12'hFFF, 12'hFFF));
        drain_results();
    endtask

    task automatic test_control_codes();
        push_request(random_payload(1'b0, 21'h000000, 1'b1));
        push_request(random_payload(1'b0, 21'h00001F, 1'b0));
        push_request(random_payload(1'b0, KEY_DEL, 1'b0));
        push_request(random_payload(1'b0, KEY_SPACE, 1'b1));
        push_request(random_payload(1'b0, 21'h00007E, 1'b1));
        push_request(random_payload(1'b0, 21'h000001, 1'b1));
        drain_results();
    endtask

    task automatic test_render_failure();
        push_request(random_payload(1'b0, 21'h004E2D, 1'b0));
        push_request(random_payload(1'b0, 21'h004E2D, 1'b1));
        push_request(random_payload(1'b0, 21'h004E2D, 1'b0));
        drain_results();
    endtask

    task automatic test_table_clear();
        push_request(make_request(1'b1, 21'h1FFFFF, 1'b1, 16'hFFFF, 12'hFFF, 12'hFFF));
        push_request(random_payload(1'b0, 21'h1FFFFF, 1'b0));
        push_request(random_payload(1'b0, 21'h004E2D, 1'b1));
        push_request(make_request(1'b1, 21'h000000, 1'b0, 16'h0000, 12'h000, 12'h000));
        push_request(random_payload(1'b0, 21'h004E2D, 1'b0));
        drain_results();
    endtask

    task automatic test_full_table();
        logic [11:0] row;
        push_request(random_payload(1'b1, 21'h0, 1'b0));
        for (int i = 0; i < TBL; i++)
        begin
            idle_on = (i < TBL / 4);
            push_request(random_payload(1'b0, {12'(i), 9'h155}, 1'b1));
        end
        idle_on = 1'b1;
        push_request(random_payload(1'b0, {12'($urandom_range(0, 12'hFFF)), 9'h0AA}, 1'b1));
        push_request(random_payload(1'b0, {12'($urandom_range(0, 12'hFFF)), 9'h0AA}, 1'b0));
        repeat (4)
        begin
            row = 12'($urandom_range(0, TBL - 1));
            push_request(random_payload(1'b0, {row, 9'h155}, 1'($urandom_range(0, 1))));
        end
        push_request(random_payload(1'b1, 21'($urandom_range(0, 21'h1FFFFF)), 1'b1));
        drain_results();
    endtask

    task automatic test_random_traffic();
        request_t         r;
        logic [KEY_W-1:0] key;
        int               pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = (n < RANDOM_ITEMS - 100) && ((n / 60) % 3 != 2);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                key = 21'($urandom_range(0, 21'h1FFFFF));
            else if (pick < 50 && recent_keys.size() != 0)
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else if (pick < 60)
                key = ($urandom_range(0, 32) == 32) ? KEY_DEL : 21'($urandom_range(0, 31));
            else if (pick < 75)
                key = 21'($urandom_range(0, 21'h1FFFFF));
            else
                key = 21'($urandom_range(32, 12'h7FF));
            r = random_payload(pick < 3, key, $urandom_range(0, 4) != 0);
            if (pick >= 50)
            begin
                recent_keys.push_back(key);
                if (recent_keys.size() > 64)
                    void'(recent_keys.pop_front());
            end
            push_request(r);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_glyphs.size() == 0)
                report_mismatch("unexpected transaction", 32'(m_tuser), '0);
            else
            begin
                want = pending_glyphs.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[15:0] !== want.handle)
                    report_mismatch("glyph_handle", 32'(m_tdata[15:0]), 32'(want.handle));
                if (m_tdata[27:16] !== want.width)
                    report_mismatch("glyph_width", 32'(m_tdata[27:16]), 32'(want.width));
                if (m_tdata[39:28] !== want.height)
                    report_mismatch("glyph_height", 32'(m_tdata[39:28]), 32'(want.height));
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_field_extremes();
        test_control_codes();
        test_render_failure();
        test_table_clear();
        test_full_table();
        test_random_traffic();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
